FILE: rtl/lwdb_pkg.sv
// package for the latest-wins double-buffer mailbox
// holds request/result structs, opcode and status codes, default sizing
// no dependencies
package lwdb_pkg;

	localparam int unsigned SET_WORDS_DEF = 32;

	typedef enum logic [1:0] {
		OP_WORD    = 2'd0,
		OP_PUBLISH = 2'd1,
		OP_APPLY   = 2'd2,
		OP_NONE    = 2'd3
	} lwdb_op_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_REFUSED  = 3'd1,
		ST_NOTHING  = 3'd2,
		ST_APPLIED  = 3'd3,
		ST_EMPTY    = 3'd4
	} lwdb_status_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] word;
		logic        final_word;
	} lwdb_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  position;
		logic [31:0] data;
		logic        run_end;
	} lwdb_out_t;

	typedef enum logic [2:0] {
		FSM_IDLE = 3'b001,
		FSM_READ = 3'b010,
		FSM_LOAD = 3'b100
	} lwdb_fsm_t;

endpackage

FILE: rtl/latest_wins_double_buffer_unit.sv
// latest-wins double buffer: set words are written while idle; publish and empty apply
// give their single result in the cycle after the request; an apply run replays each
// word (store read, then load into the output register) from the store's read port
// any request is stalled while a run is being replayed or a result waits untaken
// async active-low reset clears counters, lengths and flags; store contents stay undefined
// uses lwdb_pkg
module latest_wins_double_buffer_unit import lwdb_pkg::*; #(
	parameter int unsigned SET_WORDS = SET_WORDS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  lwdb_in_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output lwdb_out_t out_item
);

	localparam int unsigned SLOT_CAP = (SET_WORDS > 32) ? 32 : SET_WORDS;
	localparam int unsigned DEPTH    = 2 * SET_WORDS;
	localparam int unsigned ADDR_W   = $clog2(DEPTH);

	logic [31:0] store_mem [DEPTH];
	logic [31:0] rdata_q;

	lwdb_fsm_t   fsm_q;
	logic [5:0]  slot_len_q [2];
	logic [1:0]  pub_q, con_q;
	logic [5:0]  fill_q;
	logic        open_q, refused_q;
	logic [4:0]  rd_pos_q;
	logic [5:0]  rd_len_q;
	logic        rd_slot_q;
	logic        out_valid_q;
	lwdb_out_t   out_q;

	logic        accept, out_free, full, wr_slot, refuse_now, do_write, wr_en;
	logic        out_set;
	logic [5:0]  fill_cur, fill_new;
	logic [1:0]  diff;
	logic        newest;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic        rd_last;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (fsm_q == FSM_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign diff       = pub_q - con_q;
	assign full       = diff[1];
	assign wr_slot    = pub_q[0];
	assign newest     = ~pub_q[0];
	assign fill_cur   = open_q ? fill_q : 6'd0;
	assign refuse_now = open_q ? refused_q : full;
	assign do_write   = !refuse_now && (fill_cur < 6'(SLOT_CAP));
	assign fill_new   = do_write ? fill_cur + 6'd1 : fill_cur;
	assign wr_en      = accept && (in_item.opcode == OP_WORD) && do_write;
	assign wr_addr    = (wr_slot ? ADDR_W'(SET_WORDS) : '0) + ADDR_W'(fill_cur);
	assign rd_addr    = (rd_slot_q ? ADDR_W'(SET_WORDS) : '0) + ADDR_W'(rd_pos_q);
	assign rd_last    = ({1'b0, rd_pos_q} + 6'd1) == rd_len_q;

	// a result is loaded by a closing request or by each replayed word
	assign out_set = (accept && ((in_item.opcode == OP_WORD && in_item.final_word) ||
		(in_item.opcode == OP_PUBLISH) ||
		(in_item.opcode == OP_APPLY && (pub_q == con_q || slot_len_q[newest] == 6'd0)))) ||
		(fsm_q == FSM_LOAD && out_free);

	// parameter store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= in_item.word;
		end
		if (fsm_q == FSM_READ) begin
			rdata_q <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q         <= FSM_IDLE;
			slot_len_q[0] <= '0;
			slot_len_q[1] <= '0;
			pub_q         <= '0;
			con_q         <= '0;
			fill_q        <= '0;
			open_q        <= 1'b0;
			refused_q     <= 1'b0;
			rd_pos_q      <= '0;
			rd_len_q      <= '0;
			rd_slot_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (fsm_q)
				FSM_IDLE: begin
					if (accept) begin
						unique case (in_item.opcode)
							OP_WORD: begin
								if (in_item.final_word) begin
									open_q      <= 1'b0;
									refused_q   <= 1'b0;
									fill_q      <= '0;
									if (!refuse_now) begin
										slot_len_q[wr_slot] <= fill_new;
										pub_q               <= pub_q + 2'd1;
									end
								end else begin
									open_q    <= 1'b1;
									refused_q <= refuse_now;
									fill_q    <= fill_new;
								end
							end
							OP_PUBLISH: begin
								// any open set is dropped
								open_q      <= 1'b0;
								refused_q   <= 1'b0;
								fill_q      <= '0;
								if (!full) begin
									slot_len_q[wr_slot] <= '0;
									pub_q               <= pub_q + 2'd1;
								end
							end
							OP_APPLY: begin
								if (pub_q != con_q && slot_len_q[newest] != 6'd0) begin
									fsm_q <= FSM_READ;
								end
								con_q     <= pub_q;
								rd_pos_q  <= '0;
								rd_len_q  <= slot_len_q[newest];
								rd_slot_q <= newest;
							end
							OP_NONE: begin
							end
							default: begin
							end
						endcase
					end
				end
				FSM_READ: begin
					fsm_q <= FSM_LOAD;
				end
				FSM_LOAD: begin
					if (out_free) begin
						if (rd_last) begin
							fsm_q <= FSM_IDLE;
						end else begin
							rd_pos_q <= rd_pos_q + 5'd1;
							fsm_q    <= FSM_READ;
						end
					end
				end
				default: begin
					fsm_q <= FSM_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fsm_q == FSM_LOAD && out_free) begin
			out_q.status   <= ST_APPLIED;
			out_q.position <= rd_pos_q;
			out_q.data     <= rdata_q;
			out_q.run_end  <= rd_last;
		end else if (accept) begin
			out_q.position <= '0;
			out_q.data     <= '0;
			out_q.run_end  <= 1'b1;
			unique case (in_item.opcode)
				OP_WORD:    out_q.status <= refuse_now ? ST_REFUSED : ST_ACCEPTED;
				OP_PUBLISH: out_q.status <= full ? ST_REFUSED : ST_ACCEPTED;
				OP_APPLY:   out_q.status <= (pub_q == con_q) ? ST_NOTHING : ST_EMPTY;
				OP_NONE:    out_q.status <= ST_NOTHING;
				default:    out_q.status <= ST_NOTHING;
			endcase
		end
	end

endmodule
